### design/mlc_pkg.sv
// ----------------------------------------------------------------------------
// mlc_pkg: shared types, constants and helpers for the map line clipper
// Holds the controller/datapath command and status bundles, outcode bits,
// register indexes and the small coordinate helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mlc_pkg;

    // outcode bits
    localparam logic [3:0] CODE_LEFT   = 4'b0001;
    localparam logic [3:0] CODE_RIGHT  = 4'b0010;
    localparam logic [3:0] CODE_BOTTOM = 4'b0100;
    localparam logic [3:0] CODE_TOP    = 4'b1000;

    // configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LEFT   = 3'd0;
    localparam logic [2:0] CFG_WINDOW_BOTTOM = 3'd1;
    localparam logic [2:0] CFG_WINDOW_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_WINDOW_TOP    = 3'd3;
    localparam logic [2:0] CFG_SCALE         = 3'd4;
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd6;

    localparam logic [30:0] SCALE_RESET  = 31'd13107;
    localparam logic [12:0] WIDTH_RESET  = 13'd320;
    localparam logic [12:0] HEIGHT_RESET = 13'd168;

    localparam int unsigned MAX_PASSES = 8;
    localparam int unsigned DIV_STEPS  = 64;

    localparam logic signed [35:0] COORD_LIMIT = 36'sd1073741824;

    typedef struct packed {
        logic       load_in;   // capture input endpoints
        logic       map_mul;   // multiply selected coordinate by scale
        logic       map_sto;   // store selected mapped coordinate
        logic [1:0] map_idx;   // which coordinate is being mapped
        logic       setup;     // form intersection numerator and divisor
        logic       div_start; // launch the divider
        logic       upd;       // move the clipped endpoint
        logic       out_load;  // load the result register
        logic       out_vis;   // visible flag for the result
    } t_cmd;

    typedef struct packed {
        logic       rej_trivial; // both ends beyond one window edge
        logic [3:0] code_a;      // frame outcode of the first endpoint
        logic [3:0] code_b;      // frame outcode of the second endpoint
        logic       div_busy;    // divider still iterating
    } t_sts;

    function automatic logic [3:0] frame_code(
        input logic signed [31:0] x,
        input logic signed [31:0] y,
        input logic [12:0]        w,
        input logic [12:0]        h
    );
        logic [3:0] c;
        c = 4'b0000;
        if (y < 0) begin
            c = c | CODE_TOP;
        end else if (y >= $signed({19'b0, h})) begin
            c = c | CODE_BOTTOM;
        end
        if (x < 0) begin
            c = c | CODE_LEFT;
        end else if (x >= $signed({19'b0, w})) begin
            c = c | CODE_RIGHT;
        end
        return c;
    endfunction

    function automatic logic signed [31:0] saturate(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = v;
        if (v > COORD_LIMIT) begin
            r = COORD_LIMIT;
        end else if (v < -COORD_LIMIT) begin
            r = -COORD_LIMIT;
        end
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

### design/map_line_clip_to_screen.sv
// ----------------------------------------------------------------------------
// map_line_clip_to_screen: map segment to screen and clip to the frame
// Rejects segments outside the map window, maps both endpoints to pixels
// and clips them Cohen-Sutherland style against the frame.
// ----------------------------------------------------------------------------
// One segment is in flight at a time. An item goes through the window reject
// test, the mapping of the four coordinates through the single shared
// multiplier, and then up to eight clip passes, each one using the 64-step
// sequential divider that finds every edge intersection; a segment rejected
// by the window test skips the mapping and the clip passes. The result sits
// in an output register, so the next item is taken as soon as the sequencer
// returns to idle, even while the previous result waits.
// Configuration is written through a plain write port with no
// wait states; write it only while the block is idle. Clipped coordinates are
// the low 12 bits of the screen position; a rejected segment reports all
// zeros with visible low.
// ----------------------------------------------------------------------------
`default_nettype none

module map_line_clip_to_screen #(
    parameter int FRAME_X_ORIGIN = 0,
    parameter int FRAME_Y_ORIGIN = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // segment item in
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    // clipped item out
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_visible,
    output logic [11:0]        o_clip_start_x,
    output logic [11:0]        o_clip_start_y,
    output logic [11:0]        o_clip_end_x,
    output logic [11:0]        o_clip_end_y
);
    import mlc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: reject, map, clip passes, result handoff
    mlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic, endpoint storage and result register
    mlc_dp #(
        .FRAME_X_ORIGIN (FRAME_X_ORIGIN),
        .FRAME_Y_ORIGIN (FRAME_Y_ORIGIN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_visible      (o_visible),
        .o_clip_start_x (o_clip_start_x),
        .o_clip_start_y (o_clip_start_y),
        .o_clip_end_x   (o_clip_end_x),
        .o_clip_end_y   (o_clip_end_y)
    );

endmodule

`default_nettype wire

### design/mlc_div.sv
// ----------------------------------------------------------------------------
// mlc_div: sequential signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero; a zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_busy,
    output logic signed [63:0] o_quo
);
    import mlc_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [32:0]     r_rem;
    logic [63:0]     r_q;
    logic [32:0]     r_dmag;
    logic            r_neg;
    logic            r_zero;
    logic [33:0]     w_trial;
    logic [63:0]     w_nmag;
    logic [32:0]     w_dmag;

    assign w_nmag  = i_num[63] ? 64'(-i_num) : 64'(i_num);
    assign w_dmag  = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign w_trial = {r_rem, r_q[63]} - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_q    <= w_nmag;
            r_dmag <= w_dmag;
            r_neg  <= i_num[63] ^ i_den[32];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_q[63]};
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_zero ? 64'sd0 : (r_neg ? -$signed(r_q) : $signed(r_q));

endmodule

`default_nettype wire

### design/mlc_ctrl.sv
// ----------------------------------------------------------------------------
// mlc_ctrl: clipper sequencer
// Steps one segment through reject test, mapping, clip passes and result.
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mlc_pkg::t_sts   i_sts,
    output mlc_pkg::t_cmd   o_cmd
);
    import mlc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_REJ   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_STO   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SETUP = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [3:0] r_pass, n_pass;
    logic       r_vis, n_vis;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pass      = r_pass;
        n_vis       = r_vis;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.map_idx = r_idx;
        o_cmd.out_vis = r_vis;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_REJ;
                end
            end
            S_REJ: begin
                if (i_sts.rej_trivial) begin
                    n_vis   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_idx   = 2'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state = S_STO;
            end
            S_STO: begin
                o_cmd.map_sto = 1'b1;
                if (r_idx == 2'd3) begin
                    n_pass  = '0;
                    n_state = S_CHK;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_CHK: begin
                if ((i_sts.code_a & i_sts.code_b) != 4'b0000) begin
                    n_vis   = 1'b0;
                    n_state = S_FIN;
                end else if ((i_sts.code_a | i_sts.code_b) == 4'b0000) begin
                    n_vis   = 1'b1;
                    n_state = S_FIN;
                end else if (r_pass == 4'(MAX_PASSES)) begin
                    n_vis   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_pass  = r_pass + 4'd1;
                n_state = S_CHK;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pass      <= '0;
            r_vis       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pass      <= n_pass;
            r_vis       <= n_vis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### design/mlc_dp.sv
// ----------------------------------------------------------------------------
// mlc_dp: clipper datapath
// Config registers, endpoint registers, shared multiplier, divider and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_dp #(
    parameter int FRAME_X_ORIGIN = 0,
    parameter int FRAME_Y_ORIGIN = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  mlc_pkg::t_cmd      i_cmd,
    output mlc_pkg::t_sts      o_sts,
    output logic               o_visible,
    output logic [11:0]        o_clip_start_x,
    output logic [11:0]        o_clip_start_y,
    output logic [11:0]        o_clip_end_x,
    output logic [11:0]        o_clip_end_y
);
    import mlc_pkg::*;

    logic signed [31:0] r_win_left, r_win_bottom, r_win_right, r_win_top;
    logic [30:0]        r_scale;
    logic [12:0]        r_fw, r_fh;

    logic signed [31:0] r_ax, r_ay, r_bx, r_by;
    logic signed [64:0] r_prod;

    logic signed [63:0] r_num;
    logic signed [32:0] r_den;
    logic signed [31:0] r_base, r_fixed;
    logic               r_horiz, r_first;

    logic               r_vis;
    logic [11:0]        r_sx, r_sy, r_ex, r_ey;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_bottom <= '0;
            r_win_right  <= '0;
            r_win_top    <= '0;
            r_scale      <= SCALE_RESET;
            r_fw         <= WIDTH_RESET;
            r_fh         <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_LEFT:   r_win_left   <= $signed(i_cfg_data);
                CFG_WINDOW_BOTTOM: r_win_bottom <= $signed(i_cfg_data);
                CFG_WINDOW_RIGHT:  r_win_right  <= $signed(i_cfg_data);
                CFG_WINDOW_TOP:    r_win_top    <= $signed(i_cfg_data);
                CFG_SCALE:         r_scale      <= i_cfg_data[30:0];
                CFG_FRAME_WIDTH:   r_fw         <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT:  r_fh         <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // window reject test on raw endpoints (top wins over bottom, left over right)
    logic a_top, a_bot, b_top, b_bot, a_lft, a_rgt, b_lft, b_rgt;
    assign a_top = r_ay > r_win_top;
    assign a_bot = !a_top && (r_ay < r_win_bottom);
    assign b_top = r_by > r_win_top;
    assign b_bot = !b_top && (r_by < r_win_bottom);
    assign a_lft = r_ax < r_win_left;
    assign a_rgt = !a_lft && (r_ax > r_win_right);
    assign b_lft = r_bx < r_win_left;
    assign b_rgt = !b_lft && (r_bx > r_win_right);

    // mapping multiply
    logic signed [31:0] w_coord, w_org;
    logic signed [32:0] w_off;
    logic signed [64:0] w_prod;
    logic signed [32:0] w_m;
    logic signed [35:0] w_mx, w_my;
    logic signed [31:0] w_map;

    always_comb begin
        case (i_cmd.map_idx)
            2'd0:    w_coord = r_ax;
            2'd1:    w_coord = r_ay;
            2'd2:    w_coord = r_bx;
            default: w_coord = r_by;
        endcase
    end
    assign w_org  = i_cmd.map_idx[0] ? r_win_bottom : r_win_left;
    assign w_off  = 33'(w_coord) - 33'(w_org);
    assign w_prod = w_off * $signed({1'b0, r_scale});
    assign w_m    = r_prod[64:32];
    assign w_mx   = 36'(FRAME_X_ORIGIN) + 36'(w_m);
    assign w_my   = 36'(FRAME_Y_ORIGIN) + $signed({23'b0, r_fh}) - 36'(w_m);
    assign w_map  = saturate(i_cmd.map_idx[0] ? w_my : w_mx);

    // clip pass setup
    logic [3:0]         w_ca, w_cb, w_side;
    logic signed [32:0] w_dx, w_dy, w_ma, w_mb, w_den;
    logic signed [31:0] w_base, w_fixed;
    logic               w_horiz;
    logic signed [65:0] w_cprod;

    assign w_ca   = frame_code(r_ax, r_ay, r_fw, r_fh);
    assign w_cb   = frame_code(r_bx, r_by, r_fw, r_fh);
    assign w_side = (w_ca != 4'b0000) ? w_ca : w_cb;
    assign w_dx   = 33'(r_bx) - 33'(r_ax);
    assign w_dy   = 33'(r_by) - 33'(r_ay);

    always_comb begin
        if ((w_side & CODE_TOP) != 4'b0000) begin
            w_ma = w_dx;  w_mb = 33'(r_ay);
            w_den = -w_dy; w_base = r_ax;
            w_fixed = '0; w_horiz = 1'b1;
        end else if ((w_side & CODE_BOTTOM) != 4'b0000) begin
            w_ma = w_dx;  w_mb = 33'(r_ay) - $signed({20'b0, r_fh});
            w_den = -w_dy; w_base = r_ax;
            w_fixed = $signed({19'b0, r_fh}) - 32'sd1; w_horiz = 1'b1;
        end else if ((w_side & CODE_RIGHT) != 4'b0000) begin
            w_ma = w_dy;  w_mb = $signed({20'b0, r_fw}) - 33'sd1 - 33'(r_ax);
            w_den = w_dx; w_base = r_ay;
            w_fixed = $signed({19'b0, r_fw}) - 32'sd1; w_horiz = 1'b0;
        end else begin
            w_ma = w_dy;  w_mb = -33'(r_ax);
            w_den = w_dx; w_base = r_ay;
            w_fixed = '0; w_horiz = 1'b0;
        end
    end
    assign w_cprod = w_ma * w_mb;

    // divider
    logic               w_div_busy;
    logic signed [63:0] w_quo;
    logic signed [31:0] w_new, w_nx, w_ny;

    mlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    assign w_new = r_base + w_quo[31:0];
    assign w_nx  = r_horiz ? w_new : r_fixed;
    assign w_ny  = r_horiz ? r_fixed : w_new;

    // endpoint registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ax <= i_start_x;
            r_ay <= i_start_y;
            r_bx <= i_end_x;
            r_by <= i_end_y;
        end else if (i_cmd.map_sto) begin
            case (i_cmd.map_idx)
                2'd0:    r_ax <= w_map;
                2'd1:    r_ay <= w_map;
                2'd2:    r_bx <= w_map;
                default: r_by <= w_map;
            endcase
        end else if (i_cmd.upd) begin
            if (r_first) begin
                r_ax <= w_nx;
                r_ay <= w_ny;
            end else begin
                r_bx <= w_nx;
                r_by <= w_ny;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.setup) begin
            r_num   <= w_cprod[63:0];
            r_den   <= w_den;
            r_base  <= w_base;
            r_fixed <= w_fixed;
            r_horiz <= w_horiz;
            r_first <= (w_ca != 4'b0000);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_vis <= i_cmd.out_vis;
            r_sx  <= i_cmd.out_vis ? r_ax[11:0] : 12'd0;
            r_sy  <= i_cmd.out_vis ? r_ay[11:0] : 12'd0;
            r_ex  <= i_cmd.out_vis ? r_bx[11:0] : 12'd0;
            r_ey  <= i_cmd.out_vis ? r_by[11:0] : 12'd0;
        end
    end

    assign o_sts.rej_trivial = (a_top & b_top) | (a_bot & b_bot) |
                               (a_lft & b_lft) | (a_rgt & b_rgt);
    assign o_sts.code_a   = w_ca;
    assign o_sts.code_b   = w_cb;
    assign o_sts.div_busy = w_div_busy;

    assign o_visible      = r_vis;
    assign o_clip_start_x = r_sx;
    assign o_clip_start_y = r_sy;
    assign o_clip_end_x   = r_ex;
    assign o_clip_end_y   = r_ey;

endmodule

`default_nettype wire
